// ===== rtl/core/epa_pkg.sv =====
// Shared types and constants for the encoder position accumulator.
package epa_pkg;

   localparam int unsigned READING_W  = 19;
   localparam int unsigned POSITION_W = 32;
   localparam int unsigned DELTA_W    = 19;
   localparam int unsigned STEP_W     = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   // Raw difference is one bit wider than a reading so it can go negative.
   localparam int unsigned DIFF_W = READING_W + 1;

   localparam logic signed [DIFF_W-1:0] ANGLE_HALF_TURN     = 20'sd180000;
   localparam logic signed [DIFF_W-1:0] ANGLE_NEG_HALF_TURN = -20'sd180000;
   localparam logic signed [DIFF_W-1:0] ANGLE_FULL_TURN     = 20'sd360000;

   localparam logic [STEP_W-1:0] QUAD_STEP_RESET = 16'd360;

   typedef enum logic [1:0] {
      REG_MODE      = 2'd0,
      REG_INVERT    = 2'd1,
      REG_QUAD_STEP = 2'd2
   } reg_index_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_LOAD   = 1'b1
   } req_kind_type;

   typedef enum logic {
      MODE_ABSOLUTE   = 1'b0,
      MODE_QUADRATURE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic              invert;
      logic [STEP_W-1:0] quad_step;
   } cfg_type;

endpackage

// ===== rtl/core/encoder_position_accumulator.sv =====
// Top level of the encoder position accumulator: input stage, update stage, result register.
// An accepted item waits in the input register and moves to the result register when it can.
// Throughput: one item per cycle unless stalled; the update stage reads and writes the count.
// An input register ahead of the result register lets an item be taken while a result waits.
// Reset (synchronous, active high) clears the count, the reference and both valid flags,
// and sets mode to absolute, invert off and the quadrature step to 360.
module encoder_position_accumulator (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_type,
   input  logic [epa_pkg::READING_W-1:0]           req_reading,
   input  logic [epa_pkg::POSITION_W-1:0]          req_load_value,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [epa_pkg::POSITION_W-1:0]          rsp_position,
   output logic signed [epa_pkg::DELTA_W-1:0]      rsp_applied_delta,
   // Configuration port.
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [epa_pkg::CSR_ADDR_W-1:0]          paddr,
   input  logic [epa_pkg::CSR_DATA_W-1:0]          pwdata,
   output logic [epa_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   epa_pkg::cfg_type cfg;

   // Input stage.
   logic                            s1_valid_ff, s1_valid_in;
   epa_pkg::req_kind_type           s1_kind_ff;
   logic [epa_pkg::READING_W-1:0]   s1_reading_ff;
   logic [epa_pkg::POSITION_W-1:0]  s1_load_ff;

   // Tracking state.
   logic [epa_pkg::READING_W-1:0]   prev_reading_ff, prev_reading_in;
   logic [epa_pkg::POSITION_W-1:0]  position_ff, position_in;
   logic                            ref_taken_ff, ref_taken_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [epa_pkg::POSITION_W-1:0]  rsp_position_ff, rsp_position_in;
   logic signed [epa_pkg::DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;

   logic                            out_ready;
   logic                            req_accept;
   logic                            s1_fire;
   logic signed [epa_pkg::DELTA_W-1:0] sample_delta;

   epa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   epa_delta u_delta (
      .reading  (s1_reading_ff),
      .previous (prev_reading_ff),
      .cfg      (cfg),
      .delta    (sample_delta)
   );

   // The result register can take a new value when it is empty or being drained.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_ready;
   // The input stage only holds back when its item cannot move on.
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff    <= epa_pkg::req_kind_type'(req_type);
         s1_reading_ff <= req_reading;
         s1_load_ff    <= req_load_value;
      end
   end

   // Update stage: a load presets the count, the first sample only takes the
   // reference, and every later sample adds its decoded delta.
   always_comb begin
      prev_reading_in = prev_reading_ff;
      position_in     = position_ff;
      ref_taken_in    = ref_taken_ff;
      rsp_position_in = rsp_position_ff;
      rsp_delta_in    = rsp_delta_ff;
      if (s1_fire) begin
         rsp_delta_in = '0;
         if (s1_kind_ff == epa_pkg::REQ_LOAD) begin
            position_in = s1_load_ff;
         end else if (!ref_taken_ff) begin
            prev_reading_in = s1_reading_ff;
            ref_taken_in    = 1'b1;
         end else begin
            prev_reading_in = s1_reading_ff;
            position_in     = position_ff + epa_pkg::POSITION_W'(sample_delta);
            rsp_delta_in    = sample_delta;
         end
         rsp_position_in = position_in;
      end
   end

   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         ref_taken_ff    <= 1'b0;
         prev_reading_ff <= '0;
         position_ff     <= '0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         ref_taken_ff    <= ref_taken_in;
         prev_reading_ff <= prev_reading_in;
         position_ff     <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff <= rsp_position_in;
      rsp_delta_ff    <= rsp_delta_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_applied_delta = rsp_delta_ff;

endmodule

// ===== rtl/core/epa_csr.sv =====
// Configuration registers behind the APB-style port.
module epa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [epa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [epa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [epa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output epa_pkg::cfg_type                 cfg
);

   epa_pkg::cfg_type cfg_ff;
   epa_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            epa_pkg::REG_MODE: begin
               cfg_in.mode = epa_pkg::mode_type'(pwdata[0]);
            end
            epa_pkg::REG_INVERT: begin
               cfg_in.invert = pwdata[0];
            end
            epa_pkg::REG_QUAD_STEP: begin
               cfg_in.quad_step = pwdata[epa_pkg::STEP_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= epa_pkg::MODE_ABSOLUTE;
         cfg_ff.invert    <= 1'b0;
         cfg_ff.quad_step <= epa_pkg::QUAD_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         epa_pkg::REG_MODE:      prdata[0] = cfg_ff.mode;
         epa_pkg::REG_INVERT:    prdata[0] = cfg_ff.invert;
         epa_pkg::REG_QUAD_STEP: prdata[epa_pkg::STEP_W-1:0] = cfg_ff.quad_step;
         default:                prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/epa_delta.sv =====
// Delta decode: absolute unwrap or quadrature transition, then optional negation.
module epa_delta (
   input  logic [epa_pkg::READING_W-1:0]       reading,
   input  logic [epa_pkg::READING_W-1:0]       previous,
   input  epa_pkg::cfg_type                    cfg,
   output logic signed [epa_pkg::DELTA_W-1:0]  delta
);

   logic signed [epa_pkg::DIFF_W-1:0]  diff;
   logic signed [epa_pkg::DIFF_W-1:0]  unwrapped;
   logic signed [epa_pkg::DELTA_W-1:0] abs_delta;
   logic signed [epa_pkg::DELTA_W-1:0] quad_delta;
   logic signed [epa_pkg::DELTA_W-1:0] step;
   logic signed [epa_pkg::DELTA_W-1:0] raw_delta;
   logic [1:0]                         now_ph;
   logic [1:0]                         old_ph;

   assign diff = $signed({1'b0, reading}) - $signed({1'b0, previous});

   always_comb begin
      if (diff >= epa_pkg::ANGLE_HALF_TURN) begin
         unwrapped = diff - epa_pkg::ANGLE_FULL_TURN;
      end else if (diff <= epa_pkg::ANGLE_NEG_HALF_TURN) begin
         unwrapped = diff + epa_pkg::ANGLE_FULL_TURN;
      end else begin
         unwrapped = diff;
      end
   end

   // After unwrapping the value always fits in the delta width.
   assign abs_delta = unwrapped[epa_pkg::DELTA_W-1:0];

   assign now_ph = reading[1:0];
   assign old_ph = previous[1:0];
   assign step   = $signed({{(epa_pkg::DELTA_W - epa_pkg::STEP_W){1'b0}}, cfg.quad_step});

   always_comb begin
      if ((now_ph == 2'd3 && old_ph == 2'd1) || (now_ph == 2'd0 && old_ph == 2'd2)) begin
         quad_delta = step;
      end else if ((now_ph == 2'd2 && old_ph == 2'd0) || (now_ph == 2'd1 && old_ph == 2'd3)) begin
         quad_delta = -step;
      end else begin
         quad_delta = '0;
      end
   end

   assign raw_delta = (cfg.mode == epa_pkg::MODE_QUADRATURE) ? quad_delta : abs_delta;
   assign delta     = cfg.invert ? -raw_delta : raw_delta;

endmodule

// ===== rtl/core/epa_checker.sv =====
// Port-level checks for the encoder position accumulator, bound to the top level.
module epa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_type,
   input logic [epa_pkg::POSITION_W-1:0]      req_load_value,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [epa_pkg::POSITION_W-1:0]      rsp_position,
   input logic signed [epa_pkg::DELTA_W-1:0]  rsp_applied_delta
);

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_applied_delta))
      else $error("stalled result changed");

   // With no result waiting, the input side never holds back.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // A load item reports its value and a zero delta in the cycle after it moves on.
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == epa_pkg::REQ_LOAD)
         ##1 (!rsp_valid || !rsp_stall)
      |=> rsp_valid && rsp_position == $past(req_load_value, 2)
         && rsp_applied_delta == '0)
      else $error("load result wrong");

   // The unwrapped delta never exceeds a half turn.
   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_applied_delta <= 19'sd180000
         && rsp_applied_delta >= -19'sd180000)
      else $error("delta out of range");

endmodule

bind encoder_position_accumulator epa_checker u_epa_checker (.*);

// ===== sim/encoder_position_accumulator_tb.sv =====
// Self-checking testbench for the encoder position accumulator, with a built-in count predictor.
`timescale 1ns / 1ps

module encoder_position_accumulator_tb;

   // Largest value that fits in the reading field, and the top of the legal angle range.
   localparam int READING_MAX = (1 << epa_pkg::READING_W) - 1;
   localparam int ANGLE_MAX   = 359999;
   // Cycles without any handshake on either channel before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      epa_pkg::req_kind_type          kind;
      logic [epa_pkg::READING_W-1:0]  reading;
      logic [epa_pkg::POSITION_W-1:0] load_value;
   } encoder_item_type;

   typedef struct {
      logic [epa_pkg::POSITION_W-1:0] position;
      logic [epa_pkg::DELTA_W-1:0]    delta;
   } count_update_type;

   logic                                 clock;
   logic                                 reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_type = epa_pkg::REQ_SAMPLE;
   logic [epa_pkg::READING_W-1:0]        req_reading = '0;
   logic [epa_pkg::POSITION_W-1:0]       req_load_value = '0;

   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [epa_pkg::POSITION_W-1:0]       rsp_position;
   logic signed [epa_pkg::DELTA_W-1:0]   rsp_applied_delta;

   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [epa_pkg::CSR_ADDR_W-1:0]       paddr = '0;
   logic [epa_pkg::CSR_DATA_W-1:0]       pwdata = '0;
   logic [epa_pkg::CSR_DATA_W-1:0]       prdata;
   logic                                 pready;

   encoder_position_accumulator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_reading       (req_reading),
      .req_load_value    (req_load_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_applied_delta (rsp_applied_delta),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Items waiting to be offered, and the updates predicted for items already taken.
   encoder_item_type  encoder_items[$];
   count_update_type  predicted_positions[$];

   // Private copy of the accumulator state and its settings. Reset happens once, so
   // the declaration values stand for the state right after reset.
   logic [epa_pkg::POSITION_W-1:0] count_now      = '0;
   logic [epa_pkg::READING_W-1:0]  last_reading   = '0;
   logic                           reference_seen = 1'b0;
   epa_pkg::mode_type              cfg_mode       = epa_pkg::MODE_ABSOLUTE;
   logic                           cfg_invert     = 1'b0;
   logic [epa_pkg::STEP_W-1:0]     cfg_step       = epa_pkg::QUAD_STEP_RESET;

   // When set, neither side inserts idle cycles or stalls.
   bit steady = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   // Last sample reading handed to the queue, so the random part can aim its steps.
   int gen_last = 0;

   // Applies one item to the private state and returns the update the block should report.
   function automatic count_update_type advance_count(epa_pkg::req_kind_type kind,
                                                      logic [epa_pkg::READING_W-1:0] rd,
                                                      logic [epa_pkg::POSITION_W-1:0] lv);
      count_update_type   upd;
      logic signed [31:0] change;
      change = '0;
      if (kind == epa_pkg::REQ_LOAD) begin
         // A load replaces the count and leaves the reference alone.
         count_now = lv;
      end else if (!reference_seen) begin
         // The very first sample only records where the encoder stands.
         last_reading   = rd;
         reference_seen = 1'b1;
      end else begin
         if (cfg_mode == epa_pkg::MODE_ABSOLUTE) begin
            // Take the short way around the circle: a jump of half a turn or more
            // is read as motion in the other direction.
            change = $signed({13'd0, rd}) - $signed({13'd0, last_reading});
            if (change >= epa_pkg::ANGLE_HALF_TURN) begin
               change = change - epa_pkg::ANGLE_FULL_TURN;
            end else if (change <= epa_pkg::ANGLE_NEG_HALF_TURN) begin
               change = change + epa_pkg::ANGLE_FULL_TURN;
            end
         end else begin
            // Only the two phase bits matter; the pair is {previous, current}.
            case ({last_reading[1:0], rd[1:0]})
               4'b01_11, 4'b10_00: change = $signed({16'd0, cfg_step});
               4'b00_10, 4'b11_01: change = -$signed({16'd0, cfg_step});
               default:            change = '0;
            endcase
         end
         if (cfg_invert) begin
            change = -change;
         end
         last_reading = rd;
         count_now    = count_now + change;
      end
      upd.position = count_now;
      upd.delta    = change[epa_pkg::DELTA_W-1:0];
      return upd;
   endfunction

   // Driver: offers the oldest queued item, holds it while stalled, and records the
   // predicted update at the edge where the block takes it.
   always @(posedge clock) begin : drive_items
      encoder_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_positions.push_back(
               advance_count(epa_pkg::req_kind_type'(req_type), req_reading, req_load_value));
         end
         if (!req_valid || !req_stall) begin
            if (encoder_items.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
               next_item = encoder_items.pop_front();
               req_valid      <= 1'b1;
               req_type       <= next_item.kind;
               req_reading    <= next_item.reading;
               req_load_value <= next_item.load_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares every taken result with the oldest prediction and throttles
   // the result channel with random stalls.
   always @(posedge clock) begin : check_results
      count_update_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_positions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%t: result with nothing predicted: position %h delta %0d",
                           $realtime, rsp_position, rsp_applied_delta);
               end
            end else begin
               want = predicted_positions.pop_front();
               if (rsp_position !== want.position || rsp_applied_delta !== want.delta) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%t: position %h delta %0d, expected position %h delta %0d",
                              $realtime, rsp_position, rsp_applied_delta,
                              want.position, $signed(want.delta));
                  end
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 33);
      end
   end

   // Watchdog: a correct run never goes this long without a handshake on either side.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("encoder_position_accumulator_tb: done, errors");
         $finish;
      end
   end

   // One register write over the configuration port: setup cycle, then access cycle
   // held until pready is seen. The private copy follows once the write has landed.
   task automatic write_register(epa_pkg::reg_index_type idx,
                                 logic [epa_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         epa_pkg::REG_MODE:      cfg_mode   = epa_pkg::mode_type'(value[0]);
         epa_pkg::REG_INVERT:    cfg_invert = value[0];
         epa_pkg::REG_QUAD_STEP: cfg_step   = value[epa_pkg::STEP_W-1:0];
         default:                ;
      endcase
   endtask

   task automatic apply_settings(epa_pkg::mode_type m, logic inv,
                                 logic [epa_pkg::STEP_W-1:0] step_size);
      write_register(epa_pkg::REG_MODE, epa_pkg::CSR_DATA_W'(m));
      write_register(epa_pkg::REG_INVERT, epa_pkg::CSR_DATA_W'(inv));
      write_register(epa_pkg::REG_QUAD_STEP, epa_pkg::CSR_DATA_W'(step_size));
   endtask

   task automatic queue_item(epa_pkg::req_kind_type kind, int rd,
                             logic [epa_pkg::POSITION_W-1:0] lv);
      encoder_item_type item;
      item.kind       = kind;
      item.reading    = rd[epa_pkg::READING_W-1:0];
      item.load_value = lv;
      encoder_items.push_back(item);
      if (kind == epa_pkg::REQ_SAMPLE) begin
         gen_last = rd;
      end
   endtask

   // Checked at the falling edge so every posedge update has settled. The block is idle
   // once nothing is queued, nothing is offered and every prediction has been matched.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (encoder_items.size() != 0 || req_valid || predicted_positions.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Random items shaped for the current mode. In absolute mode most samples are plausible
   // encoder motion; the rest are jumps near the half-turn boundary, arbitrary angles and
   // readings above the legal range. Both modes also queue count presets.
   task automatic queue_random_items(int n);
      int unsigned                    pick;
      int                             next;
      logic [epa_pkg::POSITION_W-1:0] lv;
      repeat (n) begin
         pick = $urandom_range(99);
         lv   = $urandom;
         if (pick < 8) begin
            case ($urandom_range(3))
               0:       lv = '0;
               1:       lv = '1;
               2:       lv = 32'hFFFF_FFFF - $urandom_range(400);
               default: ;
            endcase
            queue_item(epa_pkg::REQ_LOAD, int'($urandom_range(READING_MAX)), lv);
         end else begin
            if (cfg_mode == epa_pkg::MODE_QUADRATURE) begin
               // Flipping the upper phase bit is the one legal move from any state.
               next = int'($urandom_range(READING_MAX >> 2)) * 4
                      + ((pick < 70) ? ((gen_last % 4) ^ 2) : int'($urandom_range(3)));
            end else if (pick < 60) begin
               next = gen_last + int'($urandom_range(4000)) - 2000;
               if (next < 0) begin
                  next = next + 360000;
               end else if (next > ANGLE_MAX) begin
                  next = next - 360000;
               end
            end else if (pick < 75) begin
               // Raw difference within two of the half-turn threshold, either sign.
               if (gen_last > 180001) begin
                  next = gen_last - 179998 - int'($urandom_range(4));
               end else begin
                  next = gen_last + 179998 + int'($urandom_range(4));
               end
            end else if (pick < 92) begin
               next = int'($urandom_range(ANGLE_MAX));
            end else begin
               next = int'($urandom_range(READING_MAX, ANGLE_MAX + 1));
            end
            queue_item(epa_pkg::REQ_SAMPLE, next, lv);
         end
      end
   endtask

   task automatic run_random_phase(epa_pkg::mode_type m, logic inv,
                                   logic [epa_pkg::STEP_W-1:0] step_size,
                                   int n, bit no_idle, bit pause_midway);
      apply_settings(m, inv, step_size);
      steady = no_idle;
      if (pause_midway) begin
         // The sender stops until every result so far has come back, then resumes.
         queue_random_items(n / 2);
         wait_until_drained();
         queue_random_items(n - n / 2);
      end else begin
         queue_random_items(n);
      end
      wait_until_drained();
      steady = 1'b0;
   endtask

   initial begin : stimulus
      int unsigned quad_walk[17];
      quad_walk = '{0, 0, 1, 1, 2, 2, 3, 3, 0, 2, 0, 3, 1, 3, 2, 1, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Absolute mode with the settings left by reset. A preset comes before the first
      // sample, then the unwrap boundaries are hit exactly in both directions.
      queue_item(epa_pkg::REQ_LOAD, READING_MAX, 32'h1234_5678);
      queue_item(epa_pkg::REQ_SAMPLE, 100000, '1);
      queue_item(epa_pkg::REQ_SAMPLE, ANGLE_MAX, '1);
      queue_item(epa_pkg::REQ_SAMPLE, 0, '1);
      queue_item(epa_pkg::REQ_SAMPLE, 179999, '0);
      queue_item(epa_pkg::REQ_SAMPLE, ANGLE_MAX, '0);
      queue_item(epa_pkg::REQ_SAMPLE, 179999, '1);
      queue_item(epa_pkg::REQ_SAMPLE, READING_MAX, '1);
      queue_item(epa_pkg::REQ_SAMPLE, 0, '0);
      // Count wraps past the top of its range.
      queue_item(epa_pkg::REQ_LOAD, 0, '1);
      queue_item(epa_pkg::REQ_SAMPLE, 5, '0);
      wait_until_drained();

      // Quadrature with the largest step: the walk visits every ordered pair of phase
      // states once, and the upper reading bits are noise the block must ignore.
      apply_settings(epa_pkg::MODE_QUADRATURE, 1'b0, '1);
      foreach (quad_walk[i]) begin
         queue_item(epa_pkg::REQ_SAMPLE,
                    int'($urandom_range(READING_MAX >> 2)) * 4 + int'(quad_walk[i]),
                    $urandom);
      end
      wait_until_drained();

      run_random_phase(epa_pkg::MODE_ABSOLUTE,   1'b0, epa_pkg::QUAD_STEP_RESET,
                       250, 1'b0, 1'b0);
      run_random_phase(epa_pkg::MODE_QUADRATURE, 1'b1, '0,    150, 1'b0, 1'b0);
      run_random_phase(epa_pkg::MODE_ABSOLUTE,   1'b1, 16'd1, 250, 1'b1, 1'b0);
      run_random_phase(epa_pkg::MODE_QUADRATURE, 1'b0, '1,    200, 1'b0, 1'b1);
      run_random_phase(epa_pkg::MODE_QUADRATURE, 1'b1, 16'($urandom_range(65535)),
                       200, 1'b0, 1'b0);
      run_random_phase(epa_pkg::MODE_ABSOLUTE,   1'b0, 16'($urandom_range(65535)),
                       250, 1'b0, 1'b0);

      repeat (4) @(posedge clock);
      if (predicted_positions.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted results never arrived", predicted_positions.size());
      end
      if (mismatch_count == 0) begin
         $display("encoder_position_accumulator_tb: done, clean");
      end else begin
         $display("encoder_position_accumulator_tb: done, errors");
      end
      $finish;
   end

endmodule
